@@ rtl/fsp_pkg.sv @@
// Shared types and defaults for the queue with search and palindrome check.
package fsp_pkg;

	localparam int DEF_DEPTH       = 16;
	localparam int DEF_VALUE_WIDTH = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_PAL    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

@@ rtl/fsp_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
module fsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ rtl/fifo_search_palindrome_check_top.sv @@
// Bounded queue with insert, delete, search and palindrome check over a RAM.
//
// Input channel: op and value with in_valid / in_stall. One item is taken
// at a time; in_stall stays high from acceptance until its result has been
// moved into the output register.
// Output channel: status, removed_value, found, is_palindrome with
// out_valid / out_stall. One result per item. The output register lets the
// next item be accepted while a result still waits for the receiver; when
// out_stall holds, the result stays put and the next result waits inside.
// Work done between acceptance and loading the result for out_valid:
//   insert, or any op on an empty queue: no RAM read needed
//   delete: the head entry is read in S_READ
//   search: up to count stored entries, one stored entry read per cycle
//   palindrome: up to count/2 pairs, head-side and tail-side entries
//   read together on the two RAM read ports, one pair per cycle
// The scan stops early on a match (search) or a mismatch (palindrome).
// Reset empties the queue (head, tail, count cleared); the RAM contents are
// not cleared, since data read from unoccupied slots is never used.
module fifo_search_palindrome_check_top #(
	parameter int DEPTH       = fsp_pkg::DEF_DEPTH,
	parameter int VALUE_WIDTH = fsp_pkg::DEF_VALUE_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] removed_value,
	output logic               found,
	output logic               is_palindrome
);

	import fsp_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	state_t state_q, state_nxt;

	logic [AW-1:0] head_q, tail_q, fptr_q, bptr_q;
	logic [CW-1:0] count_q, n_q, iss_q;
	logic          rd_valid_s1;
	op_t           op_q;
	logic [VALUE_WIDTH-1:0] key_q;

	status_t      res_status_q;
	logic [31:0]  res_removed_q;
	logic         res_found_q, res_pal_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic signed [31:0] out_removed_q;
	logic               out_found_q, out_pal_q;

	logic                          in_acc;
	op_t                           in_op;
	logic signed [VALUE_WIDTH-1:0] val_in;
	logic                          is_empty, is_full;
	logic [CW-1:0]                 half_cnt;
	logic                          ram_we, issue, scan_hit, scan_end, load_out;
	logic [AW-1:0]                 raddr_a;
	logic [VALUE_WIDTH-1:0]        rdata_a, rdata_b;
	logic signed [VALUE_WIDTH-1:0] rd_a_s;

	function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] p);
		return (p == '0) ? LAST_SLOT : p - 1'b1;
	endfunction

	assign in_op    = op_t'(op);
	assign val_in   = VALUE_WIDTH'(value);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == FULL_CNT);
	assign half_cnt = count_q >> 1;
	assign in_acc   = in_valid && !in_stall;
	assign raddr_a  = (state_q == S_IDLE) ? head_q : fptr_q;
	assign rd_a_s   = rdata_a;

	fsp_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (tail_q),
		.wdata  (val_in),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(bptr_q),
		.rdata_b(rdata_b)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (in_op)
						OP_INSERT: state_nxt = S_DONE;
						OP_DELETE: state_nxt = is_empty ? S_DONE : S_READ;
						OP_SEARCH: state_nxt = is_empty ? S_DONE : S_SCAN;
						default:   state_nxt = (half_cnt == '0) ? S_DONE : S_SCAN;
					endcase
				end
			end
			S_READ: state_nxt = S_DONE;
			S_SCAN: begin
				if (scan_hit || scan_end) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (load_out) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		in_stall = (state_q != S_IDLE);
		ram_we   = 1'b0;
		issue    = 1'b0;
		scan_hit = 1'b0;
		scan_end = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				ram_we = in_acc && (in_op == OP_INSERT) && !is_full;
			end
			S_SCAN: begin
				if (rd_valid_s1) begin
					if (op_q == OP_SEARCH) begin
						scan_hit = (rdata_a == key_q);
					end else begin
						scan_hit = (rdata_a != rdata_b);
					end
				end
				scan_end = rd_valid_s1 && (iss_q == n_q) && !scan_hit;
				issue    = (iss_q != n_q) && !scan_hit;
			end
			S_DONE: begin
				load_out = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rd_valid_s1 <= issue;
			if (in_acc) begin
				case (in_op)
					OP_INSERT: begin
						if (!is_full) begin
							tail_q  <= slot_next(tail_q);
							count_q <= count_q + 1'b1;
						end
					end
					OP_DELETE: begin
						if (!is_empty) begin
							head_q  <= slot_next(head_q);
							count_q <= count_q - 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Scan pointers and result fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q          <= in_op;
			key_q         <= val_in;
			fptr_q        <= head_q;
			bptr_q        <= slot_prev(tail_q);
			iss_q         <= '0;
			n_q           <= (in_op == OP_PAL) ? half_cnt : count_q;
			res_removed_q <= '0;
			res_found_q   <= 1'b0;
			res_pal_q     <= (in_op == OP_PAL);
			case (in_op)
				OP_INSERT: begin
					res_status_q <= is_full ? STAT_FULL : STAT_OK;
				end
				OP_DELETE, OP_SEARCH: begin
					res_status_q <= is_empty ? STAT_EMPTY : STAT_OK;
				end
				default: res_status_q <= STAT_OK;
			endcase
		end
		if (state_q == S_READ) begin
			res_removed_q <= 32'(rd_a_s);
		end
		if (issue) begin
			fptr_q <= slot_next(fptr_q);
			bptr_q <= slot_prev(bptr_q);
			iss_q  <= iss_q + 1'b1;
		end
		if (scan_hit) begin
			if (op_q == OP_SEARCH) begin
				res_found_q <= 1'b1;
			end else begin
				res_pal_q <= 1'b0;
			end
		end
		if (load_out) begin
			out_status_q  <= res_status_q;
			out_removed_q <= res_removed_q;
			out_found_q   <= res_found_q;
			out_pal_q     <= res_pal_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign removed_value = out_removed_q;
	assign found         = out_found_q;
	assign is_palindrome = out_pal_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_op == OP_INSERT && is_full) |=> $stable(count_q) && $stable(tail_q))
		else $error("insert on full queue changed the queue");

	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(is_empty || is_full) |-> (head_q == tail_q))
		else $error("head and tail disagree with count");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == S_SCAN))
		else $error("scan read pending outside scan");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (iss_q <= n_q))
		else $error("scan issued past its end");

endmodule
